@@ src/efsp_pkg.sv @@
// Shared types and constants for the EEG frame sample parser.
package efsp_pkg;

  localparam int unsigned ChannelsDef = 8;

  localparam logic [7:0]  HdrFirst   = 8'hC0;
  localparam logic [7:0]  HdrSecond  = 8'hA0;
  localparam int unsigned TrailBytes = 6;
  localparam int unsigned TrailW     = $clog2(TrailBytes);

  localparam int unsigned GainW      = 24;
  localparam logic [GainW-1:0] GainReset = 24'd375000;

  localparam int unsigned ChanOutW   = 3;
  localparam int unsigned RawW       = 24;
  localparam int unsigned ScaledW    = 48;

  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;
  localparam logic [PaddrW-3:0] RegGain = '0;

  typedef enum logic [2:0] {
    StHunt,
    StHdr,
    StSkip,
    StSample,
    StSpare,
    StTrail
  } frame_st_e;

  typedef enum logic [1:0] {
    PosHigh,
    PosMid,
    PosLow
  } byte_pos_e;

  typedef struct packed {
    logic [ChanOutW-1:0] channel;
    logic [RawW-1:0]     raw;
    logic                last;
  } sample_beat_t;

endpackage

@@ src/efsp_byte_if.sv @@
// Input channel: one received byte per beat.
interface efsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ src/efsp_sample_if.sv @@
// Output channel: one decoded, scaled sample per beat.
interface efsp_sample_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel;
  logic signed [23:0] raw_sample;
  logic signed [47:0] scaled_sample;
  logic               last_in_frame;

  modport source (output valid, output channel, output raw_sample, output scaled_sample,
                  output last_in_frame, input ready);
  modport sink   (input valid, input channel, input raw_sample, input scaled_sample,
                  input last_in_frame, output ready);
endinterface

@@ src/efsp_apb_regs.sv @@
// APB register block holding the gain register.
module efsp_apb_regs
  import efsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic [GainW-1:0]  gain_o
);

  logic [GainW-1:0] gain_q;
  logic             hit_gain;
  logic             wr_en;

  assign pready   = 1'b1;
  assign hit_gain = (paddr[PaddrW-1:2] == RegGain);
  assign wr_en    = psel && penable && pwrite && hit_gain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (wr_en) begin
      gain_q <= pwdata[GainW-1:0];
    end
  end

  assign prdata = hit_gain ? PdataW'(gain_q) : '0;
  assign gain_o = gain_q;

endmodule

@@ src/efsp_framer.sv @@
// Frame parser: header hunt, sample byte assembly and trailer check.
module efsp_framer
  import efsp_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  efsp_byte_if.sink     rx_i,
  output logic          beat_valid_o,
  output sample_beat_t  beat_o,
  input  logic          beat_ready_i
);

  localparam int unsigned ChanW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ChanW-1:0] ChanLast = ChanW'(CHANNELS - 1);

  frame_st_e         state_q, state_d;
  byte_pos_e         pos_q, pos_d;
  logic [ChanW-1:0]  chan_q, chan_d;
  logic [TrailW-1:0] trail_q, trail_d;
  logic [15:0]       partial_q, partial_d;

  logic         s1_valid_q, s1_valid_d;
  sample_beat_t s1_q, s1_d;

  logic fire;

  assign rx_i.ready = !s1_valid_q || beat_ready_i;
  assign fire       = rx_i.valid && rx_i.ready;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    chan_d     = chan_q;
    trail_d    = trail_q;
    partial_d  = partial_q;
    s1_valid_d = s1_valid_q && !beat_ready_i;
    s1_d       = s1_q;

    if (fire) begin
      unique case (state_q)
        StHunt: begin
          if (rx_i.rx_byte == HdrFirst) state_d = StHdr;
        end
        StHdr: begin
          state_d = (rx_i.rx_byte == HdrSecond) ? StSkip : StHunt;
        end
        StSkip: begin
          state_d = StSample;
          chan_d  = '0;
          pos_d   = PosHigh;
        end
        StSample: begin
          unique case (pos_q)
            PosHigh: begin
              partial_d = {8'h00, rx_i.rx_byte};
              pos_d     = PosMid;
            end
            PosMid: begin
              partial_d = {partial_q[7:0], rx_i.rx_byte};
              pos_d     = PosLow;
            end
            default: begin
              s1_valid_d   = 1'b1;
              s1_d.channel = ChanOutW'(chan_q);
              s1_d.raw     = {partial_q, rx_i.rx_byte};
              s1_d.last    = (chan_q == ChanLast);
              pos_d        = PosHigh;
              if (chan_q == ChanLast) begin
                state_d = StSpare;
              end else begin
                chan_d = chan_q + 1'b1;
              end
            end
          endcase
        end
        StSpare: begin
          state_d = StTrail;
          trail_d = '0;
        end
        default: begin
          // trailer: six zero bytes, anything else drops back to hunting
          if (rx_i.rx_byte != 8'h00 || trail_q == TrailW'(TrailBytes - 1)) begin
            state_d = StHunt;
          end else begin
            trail_d = trail_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StHunt;
      pos_q      <= PosHigh;
      chan_q     <= '0;
      trail_q    <= '0;
      partial_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      chan_q     <= chan_d;
      trail_q    <= trail_d;
      partial_q  <= partial_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign beat_valid_o = s1_valid_q;
  assign beat_o       = s1_q;

endmodule

@@ src/efsp_scaler.sv @@
// Gain multiply and output register.
module efsp_scaler
  import efsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_valid_i,
  input  sample_beat_t     beat_i,
  output logic             beat_ready_o,
  input  logic [GainW-1:0] gain_i,
  efsp_sample_if.source    smp_o
);

  logic                      out_valid_q;
  logic [ChanOutW-1:0]       chan_q;
  logic signed [RawW-1:0]    raw_q;
  logic signed [ScaledW-1:0] scaled_q;
  logic                      last_q;
  logic signed [RawW+GainW:0] product;
  logic                      load;

  assign beat_ready_o = !out_valid_q || smp_o.ready;
  assign load         = beat_valid_i && beat_ready_o;

  // gain is unsigned, so widen it with a zero sign bit
  assign product = $signed(beat_i.raw) * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat_ready_o) begin
      out_valid_q <= beat_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      chan_q   <= beat_i.channel;
      raw_q    <= beat_i.raw;
      scaled_q <= product[ScaledW-1:0];
      last_q   <= beat_i.last;
    end
  end

  assign smp_o.valid         = out_valid_q;
  assign smp_o.channel       = chan_q;
  assign smp_o.raw_sample    = raw_q;
  assign smp_o.scaled_sample = scaled_q;
  assign smp_o.last_in_frame = last_q;

endmodule

@@ src/eeg_frame_sample_parser.sv @@
// Top level of the EEG frame sample parser.
//
//   port    dir   kind         beat
//   rx_i    in    valid/ready  one received byte
//   smp_o   out   valid/ready  channel, raw sample, scaled sample, last flag
//   apb     in    APB r/w      gain register at byte address 0
//
// One byte is taken every cycle while rx_i.ready is high. A sample's third byte
// moves it into the parser register, then into the gain multiply register.
// Each stage holds a beat until the next one frees; rx_i.ready drops only when
// both the parser register and the output register are full and stalled.
// Reset clears the parse state to header hunting and the gain to 375000.
module eeg_frame_sample_parser
  import efsp_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  efsp_byte_if.sink         rx_i,
  efsp_sample_if.source     smp_o
);

  logic [GainW-1:0] gain;
  logic             beat_valid;
  logic             beat_ready;
  sample_beat_t     beat;

  efsp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gain_o  (gain)
  );

  efsp_framer #(
    .CHANNELS (CHANNELS)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .beat_valid_o (beat_valid),
    .beat_o       (beat),
    .beat_ready_i (beat_ready)
  );

  efsp_scaler u_scaler (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_i       (beat),
    .beat_ready_o (beat_ready),
    .gain_i       (gain),
    .smp_o        (smp_o)
  );

endmodule
